@@ hw/rtl/tbop_pkg.sv @@
package tbop_pkg;

    localparam int NUM_TIMERS_DEF  = 16;
    localparam int COUNT_WIDTH_DEF = 32;

    localparam int OP_W     = 2;
    localparam int IDX_W    = 4;
    localparam int VAL_W    = 32;
    localparam int TIU_W    = 5;
    localparam int CMP_W    = 7;
    localparam int S_DATA_W = 72;
    localparam int M_DATA_W = 8;
    localparam int APB_AW   = 3;
    localparam int APB_DW   = 32;

    typedef logic [OP_W-1:0] op_t;

    localparam op_t OP_ARM    = 2'd0;
    localparam op_t OP_DISARM = 2'd1;
    localparam op_t OP_TICK   = 2'd2;

    localparam logic [APB_AW-3:0] REG_TIMERS_IN_USE = '0;

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_SCAN  = 3'b010,
        ST_FLUSH = 3'b100
    } state_t;

    typedef struct packed {
        logic             hit;
        logic [IDX_W-1:0] idx;
        logic             rearm;
    } expiry_t;

    typedef struct packed {
        logic stall;
        logic done;
    } emit_ctl_t;

endpackage

@@ hw/rtl/tbop_cell.sv @@
module tbop_cell
    import tbop_pkg::*;
#(
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   shift_en,
    input  logic [COUNT_WIDTH-1:0] shift_count,
    input  logic [COUNT_WIDTH-1:0] shift_reload,
    input  logic                   wr_en,
    input  logic                   wr_arm,
    input  logic [COUNT_WIDTH-1:0] wr_count,
    input  logic [COUNT_WIDTH-1:0] wr_reload,
    output logic [COUNT_WIDTH-1:0] count,
    output logic [COUNT_WIDTH-1:0] reload
);

    logic [COUNT_WIDTH-1:0] count_reg;
    logic [COUNT_WIDTH-1:0] reload_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg  <= '0;
            reload_reg <= '0;
        end else if (shift_en) begin
            count_reg  <= shift_count;
            reload_reg <= shift_reload;
        end else if (wr_en) begin
            count_reg <= wr_arm ? wr_count : '0;
            if (wr_arm) begin
                reload_reg <= wr_reload;
            end
        end
    end

    assign count  = count_reg;
    assign reload = reload_reg;

endmodule

@@ hw/rtl/tbop_head.sv @@
module tbop_head
    import tbop_pkg::*;
#(
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
    input  logic                   active,
    input  logic [IDX_W-1:0]       timer_idx,
    input  logic [COUNT_WIDTH-1:0] count,
    input  logic [COUNT_WIDTH-1:0] reload,
    output logic [COUNT_WIDTH-1:0] new_count,
    output expiry_t                expiry
);

    logic [COUNT_WIDTH-1:0] dec;
    logic                   armed;

    assign dec   = count - COUNT_WIDTH'(1);
    assign armed = active && (count != '0);

    always_comb begin
        new_count    = count;
        expiry.hit   = 1'b0;
        expiry.idx   = timer_idx;
        expiry.rearm = (reload != '0);
        if (armed) begin
            if (dec == '0) begin
                new_count  = reload;
                expiry.hit = 1'b1;
            end else begin
                new_count = dec;
            end
        end
    end

endmodule

@@ hw/rtl/tbop_emit.sv @@
module tbop_emit
    import tbop_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                scan,
    input  logic                flush,
    input  expiry_t             expiry,
    output emit_ctl_t           ctl,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata,
    output logic                m_tlast
);

    logic             pend_valid_reg;
    logic [IDX_W-1:0] pend_idx_reg;
    logic             pend_rearm_reg;
    logic             out_valid_reg;
    logic             out_valid_next;
    logic [IDX_W-1:0] out_idx_reg;
    logic             out_rearm_reg;
    logic             out_last_reg;
    logic             out_free;
    logic             load_out;
    logic             take_hit;

    assign out_free  = !out_valid_reg || m_tready;
    assign ctl.stall = scan && expiry.hit && pend_valid_reg && !out_free;
    assign ctl.done  = flush && (!pend_valid_reg || out_free);
    assign take_hit  = scan && expiry.hit && !ctl.stall;
    assign load_out  = pend_valid_reg && out_free && ((scan && expiry.hit) || flush);

    always_comb begin
        out_valid_next = out_valid_reg;
        if (load_out) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
            if (take_hit) begin
                pend_valid_reg <= 1'b1;
            end else if (flush && out_free) begin
                pend_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (take_hit) begin
            pend_idx_reg   <= expiry.idx;
            pend_rearm_reg <= expiry.rearm;
        end
        if (load_out) begin
            out_idx_reg   <= pend_idx_reg;
            out_rearm_reg <= pend_rearm_reg;
            out_last_reg  <= flush;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'b000, out_rearm_reg, out_idx_reg};
    assign m_tlast  = out_last_reg;

endmodule

@@ hw/rtl/timer_bank_one_shot_periodic.sv @@
// Channel   Direction  Transaction
// s_axis    in         op, timer_index, timeout_value, reload_value (tdata)
// m_axis    out        expired_timer, rearmed (tdata); last (tlast)
// apb       in/out     timers_in_use register at byte address 0
//
// An arm or disarm transaction is taken whenever the block is idle.
// A tick rotates the ring of NUM_TIMERS cells once past the head unit, one cell a
// cycle while the output does not stall it, then flushes the last pending result.
// A stalled output holds the ring whenever a second expiry finds the result stage full.
// Reset clears every count, interval and the register, and needs no sweep.
module timer_bank_one_shot_periodic
    import tbop_pkg::*;
#(
    parameter int NUM_TIMERS  = NUM_TIMERS_DEF,
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    // op[1:0], timer_index[5:2], timeout_value[37:6], reload_value[69:38], zero[71:70]
    input  logic [S_DATA_W-1:0] s_tdata,
    output logic                m_tvalid,
    input  logic                m_tready,
    // expired_timer[3:0], rearmed[4], zero[7:5]
    output logic [M_DATA_W-1:0] m_tdata,
    output logic                m_tlast,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [APB_AW-1:0]   paddr,
    input  logic [APB_DW-1:0]   pwdata,
    output logic [APB_DW-1:0]   prdata,
    output logic                pready
);

    localparam int STEP_W = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;

    state_t state_reg;
    state_t state_next;

    logic [STEP_W-1:0] step_reg;
    logic [STEP_W-1:0] step_next;
    logic [TIU_W-1:0]  tiu_reg;

    logic [COUNT_WIDTH-1:0] cnt [NUM_TIMERS];
    logic [COUNT_WIDTH-1:0] rld [NUM_TIMERS];
    logic [COUNT_WIDTH-1:0] head_count;

    op_t              in_op;
    logic [IDX_W-1:0] in_idx;
    logic [COUNT_WIDTH-1:0] in_timeout;
    logic [COUNT_WIDTH-1:0] in_reload;

    logic [CMP_W-1:0] lim;
    logic             accept;
    logic             idx_ok;
    logic             wr_any;
    logic             wr_arm;
    logic             scan;
    logic             flush;
    logic             active;
    logic             shift_en;
    logic             step_last;
    logic             cfg_wr;
    expiry_t          expiry;
    emit_ctl_t        emit_ctl;

    assign in_op      = s_tdata[1:0];
    assign in_idx     = s_tdata[5:2];
    assign in_timeout = COUNT_WIDTH'(s_tdata[37:6]);
    assign in_reload  = COUNT_WIDTH'(s_tdata[69:38]);

    assign lim = (CMP_W'(tiu_reg) > CMP_W'(NUM_TIMERS)) ? CMP_W'(NUM_TIMERS) : CMP_W'(tiu_reg);

    assign s_tready  = (state_reg == ST_IDLE);
    assign accept    = s_tvalid && s_tready;
    assign idx_ok    = CMP_W'(in_idx) < lim;
    assign wr_arm    = (in_op == OP_ARM);
    assign wr_any    = accept && idx_ok && ((in_op == OP_ARM) || (in_op == OP_DISARM));
    assign scan      = (state_reg == ST_SCAN);
    assign flush     = (state_reg == ST_FLUSH);
    assign active    = scan && (CMP_W'(step_reg) < lim);
    assign shift_en  = scan && !emit_ctl.stall;
    assign step_last = (step_reg == STEP_W'(NUM_TIMERS - 1));

    always_comb begin
        state_next = state_reg;
        step_next  = step_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept && (in_op == OP_TICK)) begin
                    state_next = ST_SCAN;
                    step_next  = '0;
                end
            end
            ST_SCAN: begin
                if (!emit_ctl.stall) begin
                    if (step_last) begin
                        state_next = ST_FLUSH;
                    end else begin
                        step_next = step_reg + STEP_W'(1);
                    end
                end
            end
            ST_FLUSH: begin
                if (emit_ctl.done) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
            tiu_reg   <= '0;
        end else begin
            state_reg <= state_next;
            step_reg  <= step_next;
            if (cfg_wr) begin
                tiu_reg <= pwdata[TIU_W-1:0];
            end
        end
    end

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready
                    && (paddr[APB_AW-1:2] == REG_TIMERS_IN_USE);
    assign prdata = (paddr[APB_AW-1:2] == REG_TIMERS_IN_USE) ? APB_DW'(tiu_reg) : '0;

    for (genvar i = 0; i < NUM_TIMERS; i++) begin : g_cell
        logic [COUNT_WIDTH-1:0] sh_count;
        logic [COUNT_WIDTH-1:0] sh_reload;
        logic                   cell_wr;

        if (i == NUM_TIMERS - 1) begin : g_tail
            assign sh_count  = head_count;
            assign sh_reload = rld[0];
        end else begin : g_body
            assign sh_count  = cnt[i+1];
            assign sh_reload = rld[i+1];
        end

        assign cell_wr = wr_any && (CMP_W'(in_idx) == CMP_W'(i));

        tbop_cell #(
            .COUNT_WIDTH (COUNT_WIDTH)
        ) u_cell (
            .aclk         (aclk),
            .aresetn      (aresetn),
            .shift_en     (shift_en),
            .shift_count  (sh_count),
            .shift_reload (sh_reload),
            .wr_en        (cell_wr),
            .wr_arm       (wr_arm),
            .wr_count     (in_timeout),
            .wr_reload    (in_reload),
            .count        (cnt[i]),
            .reload       (rld[i])
        );
    end

    tbop_head #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_head (
        .active    (active),
        .timer_idx (IDX_W'(step_reg)),
        .count     (cnt[0]),
        .reload    (rld[0]),
        .new_count (head_count),
        .expiry    (expiry)
    );

    tbop_emit u_emit (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .scan     (scan),
        .flush    (flush),
        .expiry   (expiry),
        .ctl      (emit_ctl),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

@@ hw/rtl/tbop_checker.sv @@
module tbop_checker
    import tbop_pkg::*;
(
    input logic                aclk,
    input logic                aresetn,
    input logic                s_tvalid,
    input logic                s_tready,
    input logic [S_DATA_W-1:0] s_tdata,
    input logic                m_tvalid,
    input logic                m_tready,
    input logic [M_DATA_W-1:0] m_tdata,
    input logic                m_tlast
);

    // A tick transaction always occupies the block for at least the following cycle.
    a_tick_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && (s_tdata[1:0] == OP_TICK)) |=> !s_tready)
        else $error("input taken directly after a tick");

    // While idle, any result still waiting must be the final one of its tick.
    a_idle_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && s_tready) |-> m_tlast)
        else $error("non-final result pending while idle");

    // An arm or disarm never produces a result on its own.
    a_no_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && (s_tdata[1:0] != OP_TICK) && !m_tvalid) |=> !m_tvalid)
        else $error("result after a non-tick transaction");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tlast)))
        else $error("stalled result changed");

endmodule

bind timer_bank_one_shot_periodic tbop_checker u_tbop_checker (.*);
